[src/b6se_pkg.sv]
// Shared types for the byte-to-six-bit symbol encoder.
// Holds the request and result payload structs and the configuration constants.
// Has no dependencies; the top level and the checker import it.
`default_nettype none

package b6se_pkg;

  localparam int unsigned ByteBits      = 8;
  localparam int unsigned GroupBits     = 6;
  localparam int unsigned AlphabetWords = 8;
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 64;

  typedef struct packed {
    logic [ByteBits-1:0] data_byte;
    logic                last_byte;
  } in_req_t;

  typedef struct packed {
    logic [ByteBits-1:0] symbol;
    logic                last_of_item;
    logic                end_of_message;
  } out_rsp_t;

endpackage

`default_nettype wire

[src/byte_to_six_bit_symbol_encoder.sv]
// Byte-to-six-bit symbol encoder: an accepted request passes through the item register and
// then the result register before its first symbol is on the output, and a second symbol,
// when there is one, follows as soon as the first is taken.
// Throughput is one symbol per cycle while the output does not stall, set by the single-symbol
// output register; a request that yields two symbols stalls the next one until its second goes.
// Reset (asynchronous, active low) clears the alphabet to zero, drops any leftover bits and
// empties both pipeline registers; the block is ready for requests right after reset.
`default_nettype none

module byte_to_six_bit_symbol_encoder #(
  parameter int unsigned KEY_LENGTH = 62
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Request channel.
  input  wire logic                                   in_valid_i,
  output      logic                                   in_stall_o,
  input  wire b6se_pkg::in_req_t                      in_req_i,
  // Result channel.
  output      logic                                   out_valid_o,
  input  wire logic                                   out_stall_i,
  output      b6se_pkg::out_rsp_t                     out_rsp_o,
  // Configuration write channel.
  input  wire logic                                   cfg_valid_i,
  output      logic                                   cfg_ready_o,
  input  wire logic [b6se_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  wire logic [b6se_pkg::CfgDataWidth-1:0]      cfg_data_i
);

  import b6se_pkg::*;

  // Number of stream bits held over between bytes. Only these three amounts can occur,
  // because every byte adds eight bits and every group removes six.
  typedef enum logic [2:0] {
    LeftNone = 3'd0,
    LeftTwo  = 3'd2,
    LeftFour = 3'd4
  } left_cnt_e;

  // The alphabet: eight words of eight symbols each. Symbol j sits in byte j mod 8 of
  // word j / 8.
  logic [AlphabetWords-1:0][CfgDataWidth-1:0] word_q;

  // Leftover stream bits, right aligned, and how many of them are pending.
  logic [3:0]      left_bits_q, left_bits_d;
  left_cnt_e       left_cnt_q,  left_cnt_d;

  // Item register: the one or two six-bit groups of the request being emitted.
  logic                 item_valid_q;
  logic [GroupBits-1:0] item_grp0_q, item_grp1_q;
  logic                 item_two_q;
  logic                 item_sel_q;
  logic                 item_last_q;

  // Result register.
  logic     out_valid_q;
  out_rsp_t out_rsp_q;

  // Groups formed from the incoming byte.
  logic [GroupBits-1:0] new_grp0, new_grp1;
  logic                 new_two;

  logic                 out_load;
  logic                 item_move;
  logic                 item_final;
  logic                 item_done;
  logic                 in_accept;
  logic                 cfg_write;

  logic [GroupBits-1:0] cur_grp;
  logic [GroupBits-1:0] sym_idx;
  logic [GroupBits-1:0] mod_tbl [2**GroupBits];

  // Reduction of each possible group value into the alphabet. Values below KEY_LENGTH
  // map to themselves; the table is fixed at elaboration.
  for (genvar gi = 0; gi < 2**GroupBits; gi++) begin : g_mod_tbl
    assign mod_tbl[gi] = GroupBits'(gi % KEY_LENGTH);
  end

  // The configuration port never pushes back. Writes to an index past the last alphabet
  // word are taken and dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i[CfgIndexWidth-1:3] == '0);

  // Handshake. The result register loads whenever it is empty or being taken this cycle.
  // The item register hands one group per load to the result register; once its final
  // group goes, it can take the next request in the same cycle, which keeps single-symbol
  // requests streaming at one per cycle while the output is not stalled.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign item_move  = item_valid_q && out_load;
  assign item_final = item_sel_q || !item_two_q;
  assign item_done  = item_move && item_final;
  assign in_stall_o = item_valid_q && !item_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Regroup the leftover bits and the new byte. With two leftover bits or none, one full
  // group comes out and the rest waits, unless this is the last byte, in which case the
  // rest is padded on the right with zeros into a second group. With four leftover bits,
  // exactly two full groups come out and nothing remains.
  always_comb begin
    new_grp0    = in_req_i.data_byte[7:2];
    new_grp1    = {in_req_i.data_byte[1:0], 4'b0000};
    new_two     = in_req_i.last_byte;
    left_bits_d = {2'b00, in_req_i.data_byte[1:0]};
    left_cnt_d  = LeftTwo;
    case (left_cnt_q)
      LeftTwo: begin
        new_grp0    = {left_bits_q[1:0], in_req_i.data_byte[7:4]};
        new_grp1    = {in_req_i.data_byte[3:0], 2'b00};
        new_two     = in_req_i.last_byte;
        left_bits_d = in_req_i.data_byte[3:0];
        left_cnt_d  = LeftFour;
      end
      LeftFour: begin
        new_grp0    = {left_bits_q, in_req_i.data_byte[7:6]};
        new_grp1    = in_req_i.data_byte[5:0];
        new_two     = 1'b1;
        left_bits_d = 4'b0000;
        left_cnt_d  = LeftNone;
      end
      default: begin
        // No leftover bits: the defaults above already describe this case.
      end
    endcase
    // The last byte of a message always flushes, so the next byte starts fresh.
    if (in_req_i.last_byte) begin
      left_bits_d = 4'b0000;
      left_cnt_d  = LeftNone;
    end
  end

  // Alphabet lookup for the group that moves into the result register next.
  assign cur_grp = item_sel_q ? item_grp1_q : item_grp0_q;
  assign sym_idx = mod_tbl[cur_grp];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (cfg_write) begin
      word_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bits_q <= 4'b0000;
      left_cnt_q  <= LeftNone;
    end else if (in_accept) begin
      left_bits_q <= left_bits_d;
      left_cnt_q  <= left_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      item_sel_q   <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
      item_sel_q   <= 1'b0;
    end else if (item_done) begin
      item_valid_q <= 1'b0;
      item_sel_q   <= 1'b0;
    end else if (item_move) begin
      item_sel_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_grp0_q <= new_grp0;
      item_grp1_q <= new_grp1;
      item_two_q  <= new_two;
      item_last_q <= in_req_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_move) begin
      out_rsp_q.symbol         <= word_q[sym_idx[5:3]][{sym_idx[2:0], 3'b000} +: ByteBits];
      out_rsp_q.last_of_item   <= item_final;
      out_rsp_q.end_of_message <= item_final && item_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

[src/b6se_checker.sv]
// Port-level checker for the byte-to-six-bit symbol encoder, bound to the top level.
// Depends on b6se_pkg for the payload types.
`default_nettype none

module b6se_checker (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   out_valid_o,
  input wire logic                                   out_stall_i,
  input wire b6se_pkg::out_rsp_t                     out_rsp_o
);

  import b6se_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed or was withdrawn");

  // The end of a message is always the last symbol of its request.
  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.end_of_message |-> out_rsp_o.last_of_item)
    else $error("end of message flagged on a non-final symbol");

  // The second symbol of a request follows its first one without a gap.
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_rsp_o.last_of_item |=> out_valid_o)
    else $error("second symbol of a request did not follow at once");

endmodule

bind byte_to_six_bit_symbol_encoder b6se_checker u_b6se_checker (.*);

`default_nettype wire
